// ===== rtl/mwpo_pkg.sv =====
// mwpo_pkg: shared types, register and waveform codes, sine table entry builder
// used by every module of the multi-wave phase oscillator but the queue; depends on nothing
package mwpo_pkg;

  // fixed field widths
  localparam int AMP_W      = 15;
  localparam int SAMPLE_W   = 16;
  localparam int STEP_W     = 32;
  localparam int ROM_W      = 15;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  // register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_WAVE_SELECT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PHASE_STEP  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_AMPLITUDE   = 2'd2;

  // wave_select register codes
  localparam logic [1:0] WAVE_SINE   = 2'd0;
  localparam logic [1:0] WAVE_SAW    = 2'd1;
  localparam logic [1:0] WAVE_SQUARE = 2'd2;

  // per-beat work kind decided in the front
  typedef enum logic [1:0] {
    WK_MUTE,
    WK_SINE,
    WK_SAW,
    WK_SQUARE
  } wave_kind_t;

  // pi/2 in Q30 and the taylor series denominators (2n)(2n+1)
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DEN [8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  // one quarter-wave entry: sin(k * pi/2 / 2^qbits) in Q15, rounded half up
  function automatic logic [ROM_W-1:0] sine_entry(input int unsigned k,
                                                  input int unsigned qbits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        q;
    logic signed [63:0] sum;
    x    = (64'(k) * HALF_PI_Q30) >> qbits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DEN[n-1];
      if ((n % 2) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    q = ($unsigned(sum) + 64'd16384) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return q[ROM_W-1:0];
  endfunction

endpackage

// ===== rtl/mwpo_fifo.sv =====
// mwpo_fifo: small register queue between the front and the back
// generic width; uses no package items
module mwpo_fifo #(
  parameter int WIDTH = 35,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             full,
  output logic             not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head_data = mem_r[rd_ptr_r];
  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);

  // the front never writes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue written while full");

  // the back never reads an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue read while empty");

endmodule

// ===== rtl/mwpo_front.sv =====
// mwpo_front: accepts input beats, keeps the phase accumulator, classifies each beat
// depends on mwpo_pkg for field widths and waveform codes
module mwpo_front #(
  parameter int PHASE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic                        end_of_block,
  input  logic [1:0]                  wave_select,
  input  logic [mwpo_pkg::STEP_W-1:0] phase_step,
  input  logic [mwpo_pkg::AMP_W-1:0]  amplitude,
  input  logic                        queue_full,
  output logic                        push,
  output logic [PHASE_BITS+2:0]       push_data
);

  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [PHASE_BITS-1:0] step_w;
  mwpo_pkg::wave_kind_t  kind;

  assign in_tready = !queue_full;
  assign push      = in_tvalid && in_tready;
  assign step_w    = PHASE_BITS'(phase_step);

  // decide the work for this beat
  always_comb begin
    if (amplitude == '0) begin
      kind = mwpo_pkg::WK_MUTE;
    end else begin
      case (wave_select)
        mwpo_pkg::WAVE_SINE:   kind = mwpo_pkg::WK_SINE;
        mwpo_pkg::WAVE_SAW:    kind = mwpo_pkg::WK_SAW;
        mwpo_pkg::WAVE_SQUARE: kind = mwpo_pkg::WK_SQUARE;
        default:               kind = mwpo_pkg::WK_MUTE;
      endcase
    end
  end

  // phase advances on every beat while amplitude is nonzero
  always_comb begin
    phase_nxt = phase_r;
    if (push && (amplitude != '0)) begin
      phase_nxt = phase_r + step_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // queue entry: phase in the low bits, then kind, then end flag
  assign push_data = {end_of_block, kind, phase_r};

endmodule

// ===== rtl/mwpo_back.sv =====
// mwpo_back: table read, scaling multiply and output register for queued beats
// depends on mwpo_pkg for widths, work kinds and the sine entry builder
module mwpo_back #(
  parameter int PHASE_BITS      = 32,
  parameter int SINE_INDEX_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [mwpo_pkg::AMP_W-1:0]    amplitude,
  input  logic                          head_valid,
  input  logic [PHASE_BITS+2:0]         head_data,
  output logic                          pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [mwpo_pkg::SAMPLE_W-1:0] out_tdata,
  output logic                          out_tlast
);

  localparam int QBITS  = SINE_INDEX_BITS - 2;
  localparam int QLEN   = 1 << QBITS;
  localparam int ADDR_W = SINE_INDEX_BITS - 1;
  localparam int SPLIT  = PHASE_BITS / 2;
  localparam int HI_W   = PHASE_BITS + 1 - SPLIT;
  localparam int SUM_W  = PHASE_BITS + 16;
  localparam int AMP_W  = mwpo_pkg::AMP_W;
  localparam int ROM_W  = mwpo_pkg::ROM_W;

  typedef logic [ROM_W-1:0] rom_t [QLEN+1];

  function automatic rom_t build_rom();
    rom_t rom;
    for (int k = 0; k <= QLEN; k++) begin
      rom[k] = mwpo_pkg::sine_entry(k, QBITS);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // head entry fields
  logic [PHASE_BITS-1:0]   h_phase;
  mwpo_pkg::wave_kind_t    h_kind;
  logic                    h_last;
  logic [SINE_INDEX_BITS-1:0] h_idx;
  logic [QBITS-1:0]        h_pos;
  logic [ADDR_W-1:0]       rom_addr;
  logic [PHASE_BITS:0]     twice, full_cycle, saw_d;
  logic                    h_neg;
  logic                    adv;

  // stage 1: table word, saw distance
  logic                    s1_valid_r;
  logic [ROM_W-1:0]        rom_r;
  logic [PHASE_BITS:0]     d_s1_r;
  mwpo_pkg::wave_kind_t    kind_s1_r;
  logic                    neg_s1_r, last_s1_r;

  // stage 2: split partial products
  logic                    s2_valid_r;
  logic [PHASE_BITS:0]     mult_in;
  logic [AMP_W+HI_W-1:0]   hi_r;
  logic [AMP_W+SPLIT-1:0]  lo_r;
  logic                    neg_s2_r, last_s2_r;

  // stage 3: output register
  logic [SUM_W-1:0]          prod_sum;
  logic [AMP_W-1:0]          mag;
  logic                      out_valid_r;
  logic [mwpo_pkg::SAMPLE_W-1:0] sample_r, sample_nxt;
  logic                      last_r;

  assign adv = !out_valid_r || out_tready;
  assign pop = adv && head_valid;

  // unpack and address the quarter table, mirrored in odd quadrants
  assign h_phase  = head_data[PHASE_BITS-1:0];
  assign h_kind   = mwpo_pkg::wave_kind_t'(head_data[PHASE_BITS+1:PHASE_BITS]);
  assign h_last   = head_data[PHASE_BITS+2];
  assign h_idx    = h_phase[PHASE_BITS-1 -: SINE_INDEX_BITS];
  assign h_pos    = h_idx[QBITS-1:0];
  assign rom_addr = h_idx[QBITS] ? (ADDR_W'(QLEN) - ADDR_W'(h_pos)) : ADDR_W'(h_pos);

  // sawtooth distance from mid-cycle: |2*phase - full|
  assign twice      = {h_phase, 1'b0};
  assign full_cycle = {1'b1, {PHASE_BITS{1'b0}}};
  assign saw_d      = h_phase[PHASE_BITS-1] ? (twice - full_cycle) : (full_cycle - twice);

  // sign of the sample for each kind
  always_comb begin
    case (h_kind)
      mwpo_pkg::WK_SINE:   h_neg = h_phase[PHASE_BITS-1];
      mwpo_pkg::WK_SAW:    h_neg = !h_phase[PHASE_BITS-1];
      mwpo_pkg::WK_SQUARE: h_neg = h_phase[PHASE_BITS-1];
      default:             h_neg = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rom_r     <= SINE_ROM[rom_addr];
      d_s1_r    <= saw_d;
      kind_s1_r <= h_kind;
      neg_s1_r  <= h_neg;
      last_s1_r <= h_last;
    end
  end

  // multiplier operand, all kinds scaled so the product shifts by PHASE_BITS
  always_comb begin
    case (kind_s1_r)
      mwpo_pkg::WK_SINE:   mult_in = {1'b0, rom_r, {(PHASE_BITS-ROM_W){1'b0}}};
      mwpo_pkg::WK_SAW:    mult_in = d_s1_r;
      mwpo_pkg::WK_SQUARE: mult_in = {1'b1, {PHASE_BITS{1'b0}}};
      default:             mult_in = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hi_r      <= (AMP_W+HI_W)'(amplitude) * (AMP_W+HI_W)'(mult_in[PHASE_BITS:SPLIT]);
      lo_r      <= (AMP_W+SPLIT)'(amplitude) * (AMP_W+SPLIT)'(mult_in[SPLIT-1:0]);
      neg_s2_r  <= neg_s1_r;
      last_s2_r <= last_s1_r;
    end
  end

  // recombine, truncate toward zero, apply sign
  assign prod_sum   = (SUM_W'(hi_r) << SPLIT) + SUM_W'(lo_r);
  assign mag        = prod_sum[PHASE_BITS+AMP_W-1:PHASE_BITS];
  assign sample_nxt = neg_s2_r ? (16'd0 - {1'b0, mag}) : {1'b0, mag};

  always_ff @(posedge clk) begin
    if (adv) begin
      sample_r <= sample_nxt;
      last_r   <= last_s2_r;
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= head_valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = sample_r;
  assign out_tlast  = last_r;

  // a delivered sample never exceeds the amplitude in magnitude
  a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (($signed(sample_r) <= $signed({1'b0, amplitude})) &&
                     ($signed(sample_r) >= -$signed({1'b0, amplitude}))))
    else $error("sample magnitude above amplitude");

  // a stalled pipeline keeps its partial products
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !adv) |=> (s2_valid_r && $stable(hi_r) && $stable(lo_r)))
    else $error("partial products lost during stall");

endmodule

// ===== rtl/multi_wave_phase_oscillator.sv =====
// multi_wave_phase_oscillator: top level, configuration registers and wiring
// depends on mwpo_pkg, mwpo_front, mwpo_fifo and mwpo_back
//
// Usage:
//   Each beat on the in_ stream requests one sample; in_tdata bit 0 is the
//   end-of-block flag. Each request yields one beat on the out_ stream with
//   the signed 16-bit sample in out_tdata and the flag echoed on out_tlast.
//   The cfg_ port writes wave_select (0), phase_step (1) and amplitude (2);
//   write only while no request is in flight.
// Throughput: one sample per cycle while out_tready stays high. From an accepted
//   input beat to out_tvalid: phase add and queue write, then table read,
//   split multiply, and recombine into the output register.
// Reset: phase accumulator, registers, queue and pipeline clear at once;
//   the sine table is a constant ROM, so no clearing pass is needed.
// Stall: while out_tvalid is high and out_tready is low the back pipeline
//   holds; the front keeps accepting into a QUEUE_DEPTH-entry queue and drops
//   in_tready when it is full, so up to QUEUE_DEPTH + 3 requests are in flight.
module multi_wave_phase_oscillator #(
  parameter int PHASE_BITS      = 32,
  parameter int SINE_INDEX_BITS = 12,
  parameter int QUEUE_DEPTH     = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [0] end_of_block
  // output stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mwpo_pkg::SAMPLE_W-1:0]   out_tdata,  // [15:0] sample
  output logic                            out_tlast,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [mwpo_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [mwpo_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int ENTRY_W = PHASE_BITS + 3;

  logic [1:0]                  wave_select_r;
  logic [mwpo_pkg::STEP_W-1:0] phase_step_r;
  logic [mwpo_pkg::AMP_W-1:0]  amplitude_r;

  logic               push, pop, queue_full, queue_not_empty;
  logic [ENTRY_W-1:0] push_data, head_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_select_r <= '0;
      phase_step_r  <= '0;
      amplitude_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        mwpo_pkg::REG_WAVE_SELECT: wave_select_r <= cfg_wdata[1:0];
        mwpo_pkg::REG_PHASE_STEP:  phase_step_r  <= cfg_wdata[mwpo_pkg::STEP_W-1:0];
        mwpo_pkg::REG_AMPLITUDE:   amplitude_r   <= cfg_wdata[mwpo_pkg::AMP_W-1:0];
        default: ;
      endcase
    end
  end

  mwpo_front #(
    .PHASE_BITS (PHASE_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .end_of_block (in_tdata[0]),
    .wave_select  (wave_select_r),
    .phase_step   (phase_step_r),
    .amplitude    (amplitude_r),
    .queue_full   (queue_full),
    .push         (push),
    .push_data    (push_data)
  );

  mwpo_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_data (head_data),
    .full      (queue_full),
    .not_empty (queue_not_empty)
  );

  mwpo_back #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_INDEX_BITS (SINE_INDEX_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .amplitude  (amplitude_r),
    .head_valid (queue_not_empty),
    .head_data  (head_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== dv/mwpo_checker.sv =====
// mwpo_checker: watches the request, sample and register-write ports of the oscillator,
// predicts each sample and compares it with the output stream; depends on mwpo_pkg
module mwpo_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [0] end_of_block
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [mwpo_pkg::SAMPLE_W-1:0]   out_tdata,  // [15:0] sample
  input  logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [mwpo_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [mwpo_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;
  // 4096-point cycle, so a quarter wave has 1024 steps
  localparam int QUARTER_STEPS = 1024;
  // pi/2 as a Q30 fraction
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

  typedef struct packed {
    logic [mwpo_pkg::SAMPLE_W-1:0] sample;
    logic                          last;
  } sample_beat_t;

  sample_beat_t               expected_samples[$];
  logic [mwpo_pkg::ROM_W-1:0] quarter_q15 [QUARTER_STEPS+1];

  // predictor copy of the oscillator state and registers
  logic [mwpo_pkg::STEP_W-1:0] phase     = '0;
  logic [1:0]                  wave_sel  = '0;
  logic [mwpo_pkg::STEP_W-1:0] step      = '0;
  logic [mwpo_pkg::AMP_W-1:0]  amplitude = '0;

  // sin(k * pi/2 / 1024) in Q15 via a truncated taylor series in Q30
  function automatic logic [mwpo_pkg::ROM_W-1:0] taylor_sine_q15(input int unsigned k);
    longint unsigned angle;
    longint unsigned angle_sq;
    longint unsigned term;
    longint unsigned rounded;
    longint          acc;
    angle    = (64'(k) * QUARTER_TURN_Q30) / 64'(QUARTER_STEPS);
    angle_sq = (angle * angle) >> 30;
    term     = angle;
    acc      = $signed(angle);
    for (int n = 1; n <= 8; n++) begin
      term = ((term * angle_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    rounded = ($unsigned(acc) + 64'd16384) >> 15;
    if (rounded > 64'd32767) begin
      rounded = 64'd32767;
    end
    return rounded[mwpo_pkg::ROM_W-1:0];
  endfunction

  // sample at the current phase, truncated toward zero
  function automatic logic [mwpo_pkg::SAMPLE_W-1:0] wave_value();
    logic [11:0]                   idx;
    logic [mwpo_pkg::ROM_W-1:0]    level;
    logic [29:0]                   sine_prod;
    logic [32:0]                   doubled;
    logic [32:0]                   ramp_dist;
    logic [47:0]                   saw_prod;
    logic [mwpo_pkg::SAMPLE_W-1:0] mag;
    logic                          negative;
    mag      = '0;
    negative = 1'b0;
    if (amplitude != '0) begin
      case (wave_sel)
        mwpo_pkg::WAVE_SINE: begin
          idx = phase[31:20];
          // odd quadrants read the table mirrored, upper half is negated
          level = idx[10] ? quarter_q15[QUARTER_STEPS - int'(idx[9:0])]
                          : quarter_q15[idx[9:0]];
          sine_prod = 30'(amplitude) * 30'(level);
          mag       = 16'(sine_prod[29:15]);
          negative  = idx[11];
        end
        mwpo_pkg::WAVE_SAW: begin
          doubled   = {phase, 1'b0};
          negative  = !phase[31];
          ramp_dist = negative ? (33'h1_0000_0000 - doubled) : (doubled - 33'h1_0000_0000);
          saw_prod  = 48'(amplitude) * 48'(ramp_dist);
          mag       = saw_prod[47:32];
        end
        mwpo_pkg::WAVE_SQUARE: begin
          mag      = 16'(amplitude);
          negative = phase[31];
        end
        default: mag = '0;
      endcase
    end
    return negative ? (16'd0 - mag) : mag;
  endfunction

  initial begin
    fail_count  = 0;
    outstanding = 0;
    for (int k = 0; k <= QUARTER_STEPS; k++) begin
      quarter_q15[k] = taylor_sine_q15(k);
    end
  end

  // register writes, prediction on request beats, comparison on sample beats
  always @(posedge clk) begin
    sample_beat_t predicted;
    sample_beat_t wanted;
    if (!rst_n) begin
      phase     = '0;
      wave_sel  = '0;
      step      = '0;
      amplitude = '0;
      expected_samples.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          mwpo_pkg::REG_WAVE_SELECT: wave_sel  = cfg_wdata[1:0];
          mwpo_pkg::REG_PHASE_STEP:  step      = cfg_wdata;
          mwpo_pkg::REG_AMPLITUDE:   amplitude = cfg_wdata[mwpo_pkg::AMP_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        predicted.sample = wave_value();
        predicted.last   = in_tdata[0];
        expected_samples.push_back(predicted);
        // a silent oscillator keeps its phase
        if (amplitude != '0) begin
          phase = phase + step;
        end
      end
      if (out_tvalid && out_tready) begin
        if (expected_samples.size() == 0) begin
          if (fail_count < REPORT_LIMIT) begin
            $display("[%0t] unexpected sample beat: sample %0d last %0b", $realtime,
                     $signed(out_tdata), out_tlast);
          end
          fail_count++;
        end else begin
          wanted = expected_samples.pop_front();
          if (wanted.sample !== out_tdata || wanted.last !== out_tlast) begin
            if (fail_count < REPORT_LIMIT) begin
              $display("[%0t] sample mismatch: expected %0d last %0b, got %0d last %0b",
                       $realtime, $signed(wanted.sample), wanted.last,
                       $signed(out_tdata), out_tlast);
            end
            fail_count++;
          end
        end
      end
    end
    outstanding <= expected_samples.size();
  end

endmodule

// ===== dv/multi_wave_phase_oscillator_test.sv =====
// multi_wave_phase_oscillator_test: clock, reset, request stimulus, sample-side stalls
// and the verdict; depends on mwpo_pkg, multi_wave_phase_oscillator and mwpo_checker
module multi_wave_phase_oscillator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQUESTS = 700;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int SETTLE_CYCLES   = 8;
  // index with no register behind it, and the selector with no waveform
  localparam logic [mwpo_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [1:0]                      WAVE_NONE  = 2'd3;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [7:0]                      in_tdata   = '0;   // [0] end_of_block
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [mwpo_pkg::SAMPLE_W-1:0]   out_tdata;         // [15:0] sample
  logic                            out_tlast;
  logic                            cfg_we     = 1'b0;
  logic [mwpo_pkg::CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [mwpo_pkg::CFG_DATA_W-1:0] cfg_wdata  = '0;
  int                              fail_count;
  int                              outstanding;
  int                              cycles     = 0;
  int                              stall_left = 0;
  int                              stall_mode = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  multi_wave_phase_oscillator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  mwpo_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // sample-side backpressure: free flow, coin flips, sparse ready or long stalls
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= (stall_left % 4) == 0;
      default: out_tready <= (stall_left % 24) >= 16;
    endcase
  end

  // all registers plus the unused index, with junk above the wave_select and amplitude widths
  task automatic write_regs(input logic [1:0] wave,
                            input logic [mwpo_pkg::STEP_W-1:0] step,
                            input logic [mwpo_pkg::AMP_W-1:0] amp);
    cfg_we    <= 1'b1;
    cfg_addr  <= mwpo_pkg::REG_WAVE_SELECT;
    cfg_wdata <= ($urandom() & 32'hFFFF_FFFC) | 32'(wave);
    @(posedge clk);
    cfg_addr  <= mwpo_pkg::REG_PHASE_STEP;
    cfg_wdata <= step;
    @(posedge clk);
    cfg_addr  <= mwpo_pkg::REG_AMPLITUDE;
    cfg_wdata <= ($urandom() & 32'hFFFF_8000) | 32'(amp);
    @(posedge clk);
    cfg_addr  <= REG_UNUSED;
    cfg_wdata <= $urandom();
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // request beats in bursts with random gaps; end_of_block alternates or is random
  task automatic send_requests(input int count, input bit alternate);
    int   left;
    int   burst;
    int   gap;
    int   sent;
    logic eob;
    left = count;
    sent = 0;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      if (burst > left) begin
        burst = left;
      end
      repeat (burst) begin
        eob = alternate ? ~sent[0] : 1'($urandom_range(0, 1));
        in_tvalid <= 1'b1;
        in_tdata  <= {7'b0, eob};
        @(posedge clk);
        while (!in_tready) @(posedge clk);
        sent++;
      end
      left -= burst;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;
  endtask

  // wait for every predicted sample, then let the pipeline go quiet
  task automatic settle();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int                          sent;
    int                          run;
    logic [1:0]                  wave;
    logic [mwpo_pkg::STEP_W-1:0] step;
    logic [mwpo_pkg::AMP_W-1:0]  amp;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: silent output, frozen phase
    send_requests(2, 1'b1);
    settle();
    // full-scale sine, eighth-turn phase steps hit every quadrant boundary
    write_regs(mwpo_pkg::WAVE_SINE, 32'h2000_0000, 15'h7FFF);
    send_requests(8, 1'b1);
    settle();
    // sawtooth from the bottom of the ramp with the largest step
    write_regs(mwpo_pkg::WAVE_SAW, 32'hFFFF_FFFF, 15'h7FFF);
    send_requests(3, 1'b1);
    settle();
    // square at the smallest amplitude, flipping each half cycle
    write_regs(mwpo_pkg::WAVE_SQUARE, 32'h8000_0000, 15'd1);
    send_requests(4, 1'b1);
    settle();
    // unused selector: zeros while the phase still moves
    write_regs(WAVE_NONE, 32'h1234_5679, 15'd5);
    send_requests(2, 1'b1);
    settle();
    // zero amplitude holds the phase
    write_regs(mwpo_pkg::WAVE_SINE, 32'h0765_4321, 15'd0);
    send_requests(2, 1'b1);
    settle();

    // random register settings, each followed by a run of requests
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      wave = ($urandom_range(0, 7) == 0) ? WAVE_NONE : 2'($urandom_range(0, 2));
      case ($urandom_range(0, 5))
        0:       amp = '0;
        1:       amp = 15'h7FFF;
        2:       amp = 15'($urandom_range(1, 15));
        default: amp = 15'($urandom_range(1, 32767));
      endcase
      case ($urandom_range(0, 5))
        0:       step = '0;
        1:       step = 32'hFFFF_FFFF;
        2:       step = 32'($urandom_range(1, 255)) << 24;
        3:       step = 32'($urandom_range(1, 65535));
        default: step = $urandom();
      endcase
      run = $urandom_range(10, 60);
      write_regs(wave, step, amp);
      send_requests(run, 1'b0);
      settle();
      sent += run;
    end

    if (fail_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
